### rtl/tftpw_pkg.sv
// Package for the TFTP write receiver: transfer payload types, opcode and
// error codes, the per-cell store command and the controller state type.
// Depends on nothing; every other file in rtl/ imports it.
package tftpw_pkg;

	// Event opcodes carried by an incoming transfer.
	localparam logic [1:0] OP_TIMEOUT = 2'd0;
	localparam logic [1:0] OP_WRQ     = 2'd1;
	localparam logic [1:0] OP_DATA    = 2'd2;
	localparam logic [1:0] OP_OTHER   = 2'd3;

	// Reply kinds.
	localparam logic KIND_ACK   = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	// Error codes of an error reply.
	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_BAD_BLOCK    = 3'd1;
	localparam logic [2:0] ERR_ABANDONED    = 3'd2;
	localparam logic [2:0] ERR_UNEXPECTED   = 3'd3;
	localparam logic [2:0] ERR_EXISTS       = 3'd4;
	localparam logic [2:0] ERR_UNKNOWN_USER = 3'd5;
	localparam logic [2:0] ERR_STORE_FULL   = 3'd6;

	localparam logic [15:0] MAX_RETRIES_RESET = 16'd5;

	// One incoming event.
	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] block_number;
		logic        full_block;
		logic        foreign_client;
		logic [31:0] name_key;
	} req_item_t;

	// One outgoing reply.
	typedef struct packed {
		logic        reply_kind;
		logic [15:0] ack_block;
		logic [2:0]  error_kind;
		logic        last_reply;
	} reply_t;

	// Stack command from the controller to the key store.
	typedef struct packed {
		logic push;
		logic pop;
	} store_cmd_t;

	// Write strobes of a single key cell.
	typedef struct packed {
		logic push;
		logic pop;
	} cell_wr_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_EXEC   = 4'b0100,
		ST_EMIT   = 4'b1000
	} ctrl_state_t;

	function automatic reply_t mk_ack(input logic [15:0] blk);
		reply_t r;
		r.reply_kind = KIND_ACK;
		r.ack_block  = blk;
		r.error_kind = ERR_NONE;
		r.last_reply = 1'b0;
		return r;
	endfunction

	function automatic reply_t mk_err(input logic [2:0] err);
		reply_t r;
		r.reply_kind = KIND_ERROR;
		r.ack_block  = '0;
		r.error_kind = err;
		r.last_reply = 1'b0;
		return r;
	endfunction

endpackage

### rtl/tftpw_cell.sv
// One cell of the filename key store: holds one stored key and passes a
// probe key with its running match flag on to the next cell every cycle.
// Depends on tftpw_pkg.
module tftpw_cell import tftpw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cell_wr_t    wr,
	input  logic [31:0] wr_key,
	input  logic [31:0] prev_key,
	input  logic        prev_hit,
	output logic [31:0] next_key,
	output logic        next_hit,
	output logic        occupied
);

	logic        occ_q;
	logic [31:0] key_q;
	logic [31:0] probe_key_q;
	logic        probe_hit_q;

	// Occupancy follows the stack pushes and pops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (wr.push) begin
			occ_q <= 1'b1;
		end else if (wr.pop) begin
			occ_q <= 1'b0;
		end
	end

	// The stored key is cleared when its entry is popped.
	always_ff @(posedge clk) begin
		if (wr.push) begin
			key_q <= wr_key;
		end else if (wr.pop) begin
			key_q <= '0;
		end
	end

	// The probe moves one cell per cycle and picks up a match here.
	always_ff @(posedge clk) begin
		probe_key_q <= prev_key;
		probe_hit_q <= prev_hit | (occ_q && (key_q == prev_key));
	end

	assign next_key = probe_key_q;
	assign next_hit = probe_hit_q;
	assign occupied = occ_q;

endmodule

### rtl/tftpw_ctrl.sv
// Transfer controller of the TFTP write receiver: accepts events, keeps the
// transfer state, drives the key stack and queues up to two replies.
// Depends on tftpw_pkg; the key search result comes from the cell row.
module tftpw_ctrl import tftpw_pkg::*; #(
	parameter int NAME_SLOTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  req_item_t                           req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output reply_t                              rsp,
	input  logic                                cfg_we,
	input  logic [15:0]                         cfg_wdata,
	output logic [31:0]                         probe_key,
	input  logic                                search_hit,
	output store_cmd_t                          store_cmd,
	output logic [$clog2(NAME_SLOTS + 1) - 1:0] name_count
);

	localparam int CW  = $clog2(NAME_SLOTS + 1);
	localparam int SCW = (NAME_SLOTS > 1) ? $clog2(NAME_SLOTS) : 1;
	localparam logic [SCW-1:0] SEARCH_LAST = SCW'(NAME_SLOTS - 1);
	localparam logic [CW-1:0]  SLOTS_FULL  = CW'(NAME_SLOTS);

	ctrl_state_t  state_q;
	req_item_t    item_q;
	logic [SCW-1:0] cnt_q;
	logic [15:0]  max_retries_q;
	logic [15:0]  expected_q;
	logic         open_q;
	logic         seen_q;
	logic [15:0]  retry_q;
	logic [15:0]  acked_q;
	logic [CW-1:0] count_q;
	reply_t       res_q [2];
	logic [1:0]   nres_q;
	logic         emit_idx_q;
	reply_t       rsp_q;
	logic         rsp_valid_q;

	// Decision for the event held in item_q.
	logic [15:0]  d_expected;
	logic         d_open;
	logic         d_seen;
	logic [15:0]  d_retry;
	logic [15:0]  d_acked;
	logic         d_push;
	logic         d_pop;
	reply_t       d_res0;
	reply_t       d_res1;
	logic [1:0]   d_nres;
	logic [15:0]  retry_inc;
	logic         emit_go;
	logic         emit_last;
	reply_t       emit_rsp;

	assign retry_inc = retry_q + 16'd1;

	always_comb begin
		d_expected = expected_q;
		d_open     = open_q;
		d_seen     = seen_q;
		d_retry    = retry_q;
		d_acked    = acked_q;
		d_push     = 1'b0;
		d_pop      = 1'b0;
		d_res0     = mk_ack(16'd0);
		d_res1     = mk_ack(16'd0);
		d_nres     = 2'd0;
		case (item_q.opcode)
			OP_TIMEOUT: begin
				if (open_q) begin
					d_res0 = mk_ack(acked_q);
					d_nres = 2'd1;
					if (retry_inc >= max_retries_q) begin
						// Retry limit reached: abandon and drop the key.
						d_pop   = (count_q != '0);
						d_open  = 1'b0;
						d_retry = '0;
						d_res1  = mk_err(ERR_ABANDONED);
						d_nres  = 2'd2;
					end else begin
						d_retry = retry_inc;
					end
				end
			end
			OP_WRQ: begin
				d_nres = 2'd1;
				if (open_q) begin
					d_res0 = mk_err(ERR_UNEXPECTED);
				end else if (search_hit) begin
					d_res0 = mk_err(ERR_EXISTS);
				end else if (count_q == SLOTS_FULL) begin
					d_res0 = mk_err(ERR_STORE_FULL);
				end else begin
					d_push     = 1'b1;
					d_open     = 1'b1;
					d_seen     = 1'b1;
					d_expected = 16'd1;
					d_acked    = '0;
					d_retry    = '0;
					d_res0     = mk_ack(16'd0);
				end
			end
			OP_DATA: begin
				d_nres = 2'd1;
				if (open_q && item_q.foreign_client) begin
					d_res0 = mk_err(ERR_UNEXPECTED);
				end else if (!seen_q) begin
					d_res0 = mk_err(ERR_UNKNOWN_USER);
				end else if (!open_q) begin
					// Closed transfer: only a repeat of the last block is acked.
					if (item_q.block_number == acked_q) begin
						d_res0 = mk_ack(item_q.block_number);
					end else begin
						d_res0 = mk_err(ERR_BAD_BLOCK);
					end
				end else if (item_q.block_number != expected_q) begin
					d_pop   = (count_q != '0);
					d_open  = 1'b0;
					d_retry = '0;
					d_res0  = mk_err(ERR_BAD_BLOCK);
				end else begin
					d_acked = item_q.block_number;
					d_retry = '0;
					d_res0  = mk_ack(item_q.block_number);
					if (item_q.full_block) begin
						d_expected = expected_q + 16'd1;
					end else begin
						d_open = 1'b0;
					end
				end
			end
			default: begin
				d_nres = 2'd0;
			end
		endcase
	end

	// Reply staging: a queued reply moves once the output register frees up.
	assign emit_go   = (state_q == ST_EMIT) && (!rsp_valid_q || rsp_ready);
	assign emit_last = (nres_q == 2'd1) || emit_idx_q;
	always_comb begin
		emit_rsp            = res_q[emit_idx_q];
		emit_rsp.last_reply = emit_last;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			emit_idx_q <= 1'b0;
			nres_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						cnt_q   <= '0;
						state_q <= (req.opcode == OP_WRQ) ? ST_SEARCH : ST_EXEC;
					end
				end
				ST_SEARCH: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SEARCH_LAST) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					nres_q     <= d_nres;
					emit_idx_q <= 1'b0;
					state_q    <= (d_nres == 2'd0) ? ST_IDLE : ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						emit_idx_q <= 1'b1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Event and reply payload registers.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
		end
		if (state_q == ST_EXEC) begin
			res_q[0] <= d_res0;
			res_q[1] <= d_res1;
		end
		if (emit_go) begin
			rsp_q <= emit_rsp;
		end
	end

	// Transfer state, updated once per event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_retries_q <= MAX_RETRIES_RESET;
			expected_q    <= 16'd1;
			open_q        <= 1'b0;
			seen_q        <= 1'b0;
			retry_q       <= '0;
			acked_q       <= '0;
			count_q       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_retries_q <= cfg_wdata;
			end
			if (state_q == ST_EXEC) begin
				expected_q <= d_expected;
				open_q     <= d_open;
				seen_q     <= d_seen;
				retry_q    <= d_retry;
				acked_q    <= d_acked;
				if (d_push) begin
					count_q <= count_q + 1'b1;
				end else if (d_pop) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (emit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready      = (state_q == ST_IDLE);
	assign rsp_valid      = rsp_valid_q;
	assign rsp            = rsp_q;
	assign probe_key      = item_q.name_key;
	assign store_cmd.push = (state_q == ST_EXEC) && d_push;
	assign store_cmd.pop  = (state_q == ST_EXEC) && d_pop;
	assign name_count     = count_q;

endmodule

### rtl/tftp_write_receiver.sv
// Top level of the TFTP write receiver: the transfer controller and a row
// of key cells that hold the used filename keys as a stack.
// Depends on tftpw_pkg, tftpw_ctrl and tftpw_cell.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_item_t (one event)
//   rsp       out        rsp_valid/rsp_ready   reply_t (one reply)
//   cfg       in         cfg_we                cfg_wdata (max_retries)
//
// One event at a time. A write request sends its key through the row of
// NAME_SLOTS cells, so its first reply reaches the output register only
// after the search, the decision and the emit states; other events skip the
// search. A second reply is loaded at the edge that hands the first one over,
// and a reply that rsp_ready holds back delays the next one. req_ready rises
// at the edge that loads the last reply of an event.
// Reset clears the transfer state, the stack count and every cell's
// occupancy at once; no clearing pass is needed.
module tftp_write_receiver import tftpw_pkg::*; #(
	parameter int NAME_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_item_t   req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output reply_t      rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int CW = $clog2(NAME_SLOTS + 1);

	logic [31:0]          chain_key [NAME_SLOTS + 1];
	logic                 chain_hit [NAME_SLOTS + 1];
	logic [NAME_SLOTS-1:0] occ;
	store_cmd_t           store_cmd;
	logic [CW-1:0]        name_count;

	tftpw_ctrl #(
		.NAME_SLOTS(NAME_SLOTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.probe_key  (chain_key[0]),
		.search_hit (chain_hit[NAME_SLOTS]),
		.store_cmd  (store_cmd),
		.name_count (name_count)
	);

	assign chain_hit[0] = 1'b0;

	// Row of key cells; a push lands at the stack top, a pop clears below it.
	for (genvar i = 0; i < NAME_SLOTS; i++) begin : g_cell
		localparam logic [CW-1:0] IDX      = CW'(i);
		localparam logic [CW-1:0] IDX_NEXT = CW'(i + 1);
		cell_wr_t wr;

		assign wr.push = store_cmd.push && (name_count == IDX);
		assign wr.pop  = store_cmd.pop && (name_count == IDX_NEXT);

		tftpw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr       (wr),
			.wr_key   (chain_key[0]),
			.prev_key (chain_key[i]),
			.prev_hit (chain_hit[i]),
			.next_key (chain_key[i + 1]),
			.next_hit (chain_hit[i + 1]),
			.occupied (occ[i])
		);
	end

	// The stack never holds more keys than there are cells.
	assert property (@(posedge clk) disable iff (!arst_n)
		name_count <= CW'(NAME_SLOTS))
		else $error("key stack count exceeds the number of cells");

	// Occupied cells always match the stack count.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ) == 32'(name_count))
		else $error("cell occupancy disagrees with the stack count");

	// A push and a pop never come from the same event.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(store_cmd.push && store_cmd.pop))
		else $error("key stack pushed and popped together");

	// A pop only happens with at least one key stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		store_cmd.pop |-> (name_count != '0))
		else $error("key stack popped while empty");

endmodule

### tb/tftp_write_receiver_tb.sv
// Self-checking testbench for the TFTP write receiver: directed and random event
// streams with random idling on both channels, checked reply by reply.
// Depends on tftpw_pkg and the tftp_write_receiver RTL.
`timescale 1ns / 100ps

module tftp_write_receiver_tb;
	import tftpw_pkg::*;

	localparam int NAME_SLOTS   = 16;
	// Cycles a reply-less event may still keep the block busy (key scan plus margin).
	localparam int TAIL_CYCLES  = NAME_SLOTS + 24;
	localparam int RUN_LIMIT_NS = 10_000_000;
	localparam int HOLD_CYCLES  = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_item_t   req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	reply_t      rsp;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// Shadow of the receiver state, advanced once per accepted event.
	logic [15:0] retry_limit = MAX_RETRIES_RESET;
	logic [15:0] exp_block = 16'd1;
	logic        xfer_open = 1'b0;
	logic        write_seen = 1'b0;
	logic [15:0] retries = '0;
	logic [15:0] acked_blk = '0;
	logic [31:0] key_stack [NAME_SLOTS];
	int          key_count = 0;

	reply_t expected_replies [$];
	int     mismatches = 0;
	int     events_sent = 0;

	// Idling controls for the two channels.
	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;
	bit rsp_taken = 1'b0;
	int rsp_wait = 0;
	int hold_left = 0;

	tftp_write_receiver #(.NAME_SLOTS(NAME_SLOTS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Clock: 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit in case the block hangs.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Mismatches found");
		$finish;
	end

	// Build one expected reply.
	function automatic reply_t reply_of(input logic kind, input logic [15:0] blk,
			input logic [2:0] err);
		reply_t r;
		r.reply_kind = kind;
		r.ack_block  = blk;
		r.error_kind = err;
		r.last_reply = 1'b0;
		return r;
	endfunction

	// Close the open transfer and give back the most recent key.
	task automatic drop_transfer();
		if (key_count > 0) begin
			key_count--;
			key_stack[key_count] = '0;
		end
		xfer_open = 1'b0;
		retries = '0;
	endtask

	function automatic logic key_held(input logic [31:0] key);
		for (int i = 0; i < key_count; i++)
			if (key_stack[i] == key)
				return 1'b1;
		return 1'b0;
	endfunction

	// Work out the replies of one accepted event and queue them.
	task automatic predict_replies(input req_item_t it);
		reply_t staged [$];
		case (it.opcode)
			OP_OTHER: ;
			OP_TIMEOUT: begin
				if (xfer_open) begin
					retries = retries + 16'd1;
					staged = {staged, reply_of(KIND_ACK, acked_blk, ERR_NONE)};
					if (retries >= retry_limit) begin
						drop_transfer();
						staged = {staged, reply_of(KIND_ERROR, '0, ERR_ABANDONED)};
					end
				end
			end
			default: begin
				if (xfer_open && it.foreign_client) begin
					staged = {staged, reply_of(KIND_ERROR, '0, ERR_UNEXPECTED)};
				end else if (it.opcode == OP_WRQ) begin
					if (xfer_open)
						staged = {staged, reply_of(KIND_ERROR, '0, ERR_UNEXPECTED)};
					else if (key_held(it.name_key))
						staged = {staged, reply_of(KIND_ERROR, '0, ERR_EXISTS)};
					else if (key_count >= NAME_SLOTS)
						staged = {staged, reply_of(KIND_ERROR, '0, ERR_STORE_FULL)};
					else begin
						key_stack[key_count] = it.name_key;
						key_count++;
						xfer_open = 1'b1;
						write_seen = 1'b1;
						exp_block = 16'd1;
						acked_blk = '0;
						retries = '0;
						staged = {staged, reply_of(KIND_ACK, '0, ERR_NONE)};
					end
				end else if (!write_seen) begin
					staged = {staged, reply_of(KIND_ERROR, '0, ERR_UNKNOWN_USER)};
				end else if (!xfer_open) begin
					// Closed transfer: only a repeat of the last acked block is acked.
					if (it.block_number == acked_blk)
						staged = {staged, reply_of(KIND_ACK, it.block_number, ERR_NONE)};
					else
						staged = {staged, reply_of(KIND_ERROR, '0, ERR_BAD_BLOCK)};
				end else if (it.block_number != exp_block) begin
					drop_transfer();
					staged = {staged, reply_of(KIND_ERROR, '0, ERR_BAD_BLOCK)};
				end else begin
					acked_blk = it.block_number;
					retries = '0;
					staged = {staged, reply_of(KIND_ACK, it.block_number, ERR_NONE)};
					if (it.full_block)
						exp_block = exp_block + 16'd1;
					else
						xfer_open = 1'b0;
				end
			end
		endcase
		if (staged.size() > 0)
			staged[staged.size() - 1].last_reply = 1'b1;
		expected_replies = {expected_replies, staged};
	endtask

	function automatic req_item_t event_of(input logic [1:0] op, input logic [15:0] blk,
			input logic full, input logic foreign, input logic [31:0] key);
		req_item_t it;
		it.opcode         = op;
		it.block_number   = blk;
		it.full_block     = full;
		it.foreign_client = foreign;
		it.name_key       = key;
		return it;
	endfunction

	function automatic req_item_t noise_event();
		return event_of(2'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), $urandom);
	endfunction

	// Offer one event, wait for its transfer, then predict its replies.
	task automatic send_event(input req_item_t it);
		int gap;
		gap = sender_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(negedge clk); while (!req_ready);
		@(posedge clk);
		predict_replies(it);
		events_sent++;
	endtask

	task automatic send_timeout();
		req_item_t it;
		it = noise_event();
		it.opcode = OP_TIMEOUT;
		send_event(it);
	endtask

	task automatic send_data(input logic [15:0] blk, input logic full);
		req_item_t it;
		it = noise_event();
		it.opcode = OP_DATA;
		it.block_number = blk;
		it.full_block = full;
		it.foreign_client = 1'b0;
		send_event(it);
	endtask

	task automatic send_bad_block();
		send_data(exp_block + 16'($urandom_range(1, 65535)), 1'($urandom));
	endtask

	// Stop offering, wait for every expected reply, then let the block go quiet.
	task automatic settle();
		req_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_retry_limit(input logic [15:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		retry_limit = value;
	endtask

	// Receiver: random stall after each transfer, plus an optional long hold.
	always @(posedge clk) begin
		if (rsp_taken) begin
			rsp_taken = 1'b0;
			rsp_wait = receiver_idle ? $urandom_range(0, 19) : 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (rsp_wait > 0) begin
			rsp_wait--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Reply checker: a transfer seen here completes at the next rising edge.
	always @(negedge clk) begin : check_replies
		reply_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_taken = 1'b1;
			if (expected_replies.size() == 0) begin
				$error("unexpected reply: kind %0d, ack_block %0d, error_kind %0d",
					rsp.reply_kind, rsp.ack_block, rsp.error_kind);
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				check_field("reply_kind", 32'(want.reply_kind), 32'(rsp.reply_kind));
				check_field("ack_block", 32'(want.ack_block), 32'(rsp.ack_block));
				check_field("error_kind", 32'(want.error_kind), 32'(rsp.error_kind));
				check_field("last_reply", 32'(want.last_reply), 32'(rsp.last_reply));
			end
		end
	end

	// Every opcode and reply kind at least once, at the reset retry limit of five.
	task automatic test_directed_events();
		send_event(event_of(OP_DATA, 16'd1, 1'b1, 1'b1, 32'h0));   // no write yet
		send_event(event_of(OP_OTHER, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
		send_event(event_of(OP_TIMEOUT, 16'h0, 1'b0, 1'b0, 32'h0)); // idle timeout
		send_event(event_of(OP_WRQ, 16'h0, 1'b0, 1'b0, 32'h0));
		send_event(event_of(OP_WRQ, 16'h0, 1'b0, 1'b0, 32'h1));     // already busy
		send_event(event_of(OP_DATA, 16'd1, 1'b1, 1'b1, 32'h0));   // foreign client
		send_event(event_of(OP_WRQ, 16'h0, 1'b0, 1'b1, 32'h2));
		send_data(16'd1, 1'b1);
		send_timeout();
		send_event(event_of(OP_OTHER, 16'h0, 1'b0, 1'b0, 32'h0));
		send_data(16'd2, 1'b1);
		send_data(16'd3, 1'b0);                                     // final block
		send_data(16'd3, 1'b1);                                     // repeat after close
		send_data(16'hFFFF, 1'b1);
		send_timeout();
		send_event(event_of(OP_WRQ, 16'h0, 1'b0, 1'b0, 32'h0));     // file exists
		send_event(event_of(OP_WRQ, 16'hFFFF, 1'b1, 1'b0, 32'hFFFF_FFFF));
		send_data(16'd0, 1'b1);                                     // out of order
		send_event(event_of(OP_WRQ, 16'h0, 1'b0, 1'b0, 32'hFFFF_FFFF));
		repeat (5) send_timeout();                                  // last one abandons
		send_data(16'd0, 1'b0);
	endtask

	// Lowest and highest retry limits.
	task automatic test_retry_limits();
		write_retry_limit(16'd1);
		send_event(event_of(OP_WRQ, 16'($urandom), 1'($urandom), 1'b0, $urandom));
		send_timeout();
		write_retry_limit(16'hFFFF);
		send_event(event_of(OP_WRQ, 16'($urandom), 1'($urandom), 1'b0, $urandom));
		repeat (12) send_timeout();
		send_bad_block();
	endtask

	// Receiver holds off while events keep coming, so the block backs up.
	task automatic test_backpressure();
		req_item_t it;
		sender_idle = 1'b0;
		@(negedge clk);
		hold_left = HOLD_CYCLES;
		@(posedge clk);
		send_event(event_of(OP_WRQ, 16'h0, 1'b0, 1'b0, $urandom));
		repeat (30) begin
			it = noise_event();
			it.opcode = ($urandom_range(0, 2) == 0) ? OP_TIMEOUT : OP_DATA;
			it.foreign_client = 1'b1;
			send_event(it);
		end
		send_bad_block();
		sender_idle = 1'b1;
	endtask

	// One well-formed transfer with random content, some noise and a random ending.
	task automatic random_transfer();
		req_item_t it;
		int n_blocks;
		int ending;
		it = noise_event();
		it.opcode = OP_WRQ;
		it.foreign_client = ($urandom_range(0, 15) == 0);
		if (key_count > 0 && $urandom_range(0, 7) == 0)
			it.name_key = key_stack[$urandom_range(0, key_count - 1)];
		send_event(it);
		n_blocks = $urandom_range(0, 6);
		for (int i = 0; i < n_blocks && xfer_open; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_event(noise_event());
			if ($urandom_range(0, 4) == 0)
				send_timeout();
			send_data(exp_block, 1'b1);
		end
		ending = $urandom_range(0, 11);
		if (xfer_open) begin
			// Completed transfers keep their key, so they are kept rare.
			if (ending == 0 && key_count < NAME_SLOTS - 2) begin
				send_data(exp_block, 1'b0);
				if ($urandom_range(0, 1) == 1)
					send_data($urandom_range(0, 1) ? acked_blk : 16'($urandom), 1'($urandom));
			end else if (ending <= 4) begin
				send_bad_block();
			end else if (ending <= 8) begin
				for (int i = 0; i < 6 && xfer_open; i++)
					send_timeout();
				if (xfer_open)
					send_bad_block();
			end
		end
	endtask

	task automatic test_random_transfers();
		logic [15:0] limits [4] = '{16'd2, 16'd1, 16'hFFFF, 16'd7};
		int target;
		foreach (limits[p]) begin
			write_retry_limit(limits[p]);
			target = events_sent + 100;
			while (events_sent < target) begin
				sender_idle = ($urandom_range(0, 3) != 0);
				receiver_idle = ($urandom_range(0, 3) != 0);
				random_transfer();
			end
		end
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
	endtask

	// Fill the key store, then try a stored key and one key too many.
	task automatic test_store_full();
		if (xfer_open)
			send_bad_block();
		while (key_count < NAME_SLOTS) begin
			send_event(event_of(OP_WRQ, 16'($urandom), 1'($urandom), 1'b0, $urandom));
			if (xfer_open)
				send_data(16'd1, 1'b0);
		end
		send_event(event_of(OP_WRQ, 16'h0, 1'b0, 1'b0, key_stack[0]));
		send_event(event_of(OP_WRQ, 16'h0, 1'b0, 1'b0, $urandom));
		send_data(acked_blk, 1'b1);
		send_timeout();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_events();
		test_retry_limits();
		test_backpressure();
		test_random_transfers();
		test_store_full();
		settle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
